/* sv/fifo_with_search_and_remove_macros.svh */
// ----------------------------------------------------------------------------
// fifo_with_search_and_remove_macros.svh
// Assertion macros for the queue block. Clock is clk, reset is rst.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_SEARCH_AND_REMOVE_MACROS_SVH
`define FIFO_WITH_SEARCH_AND_REMOVE_MACROS_SVH

// Same-cycle implication.
`define FWSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fwsr_pkg.sv */
// ----------------------------------------------------------------------------
// fwsr_pkg
// Types and constants shared by the queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package fwsr_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int LEN_W  = 5;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  out_value;
    logic [POS_W-1:0]          position;
    logic [LEN_W-1:0]          length;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // load item, issue read of head
    logic quick;       // result known at accept (push, or empty queue)
    logic pop_done;
    logic scan_step;
    logic find_hit;
    logic miss;
    logic shift_start;
    logic shift_step;
    logic shift_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;       // kind of the item in flight
    logic  empty;
    logic  hit;        // read data matches key
    logic  last;       // compared entry is the last valid one
    logic  more;       // shift data still inside the queue
  } stat_t;

endpackage

/* sv/fwsr_ctrl.sv */
// ----------------------------------------------------------------------------
// fwsr_ctrl
// Sequencer for the queue: accept, pop read, search walk and shift-down.
// ----------------------------------------------------------------------------
module fwsr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fwsr_pkg::kind_t in_kind,
  input  fwsr_pkg::stat_t st,
  output logic            busy,
  output fwsr_pkg::cmd_t  cmd
);

  fwsr_pkg::state_t state, state_next;
  logic             quick_case;

  assign quick_case = (in_kind == fwsr_pkg::KIND_PUSH) || st.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fwsr_pkg::ST_IDLE: begin
        if (start && !quick_case) begin
          state_next = (in_kind == fwsr_pkg::KIND_POP) ? fwsr_pkg::ST_POP
                                                       : fwsr_pkg::ST_SCAN;
        end
      end
      fwsr_pkg::ST_POP: begin
        state_next = fwsr_pkg::ST_IDLE;
      end
      fwsr_pkg::ST_SCAN: begin
        if (st.hit) begin
          state_next = (st.kind == fwsr_pkg::KIND_REMOVE) ? fwsr_pkg::ST_SHIFT
                                                          : fwsr_pkg::ST_IDLE;
        end else if (st.last) begin
          state_next = fwsr_pkg::ST_IDLE;
        end
      end
      fwsr_pkg::ST_SHIFT: begin
        if (!st.more) begin
          state_next = fwsr_pkg::ST_IDLE;
        end
      end
      default: state_next = fwsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != fwsr_pkg::ST_IDLE);
    case (state)
      fwsr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          cmd.quick  = quick_case;
        end
      end
      fwsr_pkg::ST_POP: begin
        cmd.pop_done = 1'b1;
      end
      fwsr_pkg::ST_SCAN: begin
        if (st.hit) begin
          if (st.kind == fwsr_pkg::KIND_REMOVE) begin
            cmd.shift_start = 1'b1;
          end else begin
            cmd.find_hit = 1'b1;
          end
        end else if (st.last) begin
          cmd.miss = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      fwsr_pkg::ST_SHIFT: begin
        if (st.more) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.shift_done = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* sv/fwsr_dpath.sv */
// ----------------------------------------------------------------------------
// fwsr_dpath
// Circular entry store with head pointer and count, search index, and the
// result register.
// ----------------------------------------------------------------------------
module fwsr_dpath #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  fwsr_pkg::item_t   item,
  input  fwsr_pkg::cmd_t    cmd,
  output fwsr_pkg::stat_t   st,
  output logic              done,
  output fwsr_pkg::result_t result
);

  localparam int DW = fwsr_pkg::DATA_W;
  localparam int PW = fwsr_pkg::POS_W;
  localparam int LW = fwsr_pkg::LEN_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH + 2);
  localparam logic [AW+1:0] DEPTH_W = (AW+2)'(DEPTH);

  logic [DW-1:0]   mem [DEPTH];
  logic [DW-1:0]   rdata;
  logic [AW-1:0]   raddr, waddr;
  logic [DW-1:0]   wdata;
  logic            we;

  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [IW-1:0]   idx;       // next index to read; rdata holds idx-1
  logic [IW-1:0]   pos;
  logic [DW-1:0]   key;
  fwsr_pkg::kind_t kind;
  logic            full;
  logic            push_ok;

  // head + offset modulo DEPTH; both operands below DEPTH+2
  function automatic logic [AW-1:0] wrap(input logic [AW:0] base,
                                         input logic [AW:0] off);
    logic [AW+1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign push_ok = cmd.quick && (item.kind == fwsr_pkg::KIND_PUSH) && !full;

  assign raddr = cmd.accept ? head : wrap({1'b0, head}, (AW+1)'(idx));
  assign we    = push_ok || cmd.shift_step;
  assign waddr = push_ok ? wrap({1'b0, head}, (AW+1)'(count))
                         : wrap({1'b0, head}, (AW+1)'(idx - IW'(2)));
  assign wdata = push_ok ? item.value : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign st.kind  = kind;
  assign st.empty = (count == '0);
  assign st.hit   = (rdata == key);
  assign st.last  = (IW'(count) <= idx);
  assign st.more  = (idx <= IW'(count));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.quick || cmd.pop_done || cmd.find_hit || cmd.miss || cmd.shift_done;
      if (push_ok) begin
        count <= count + CW'(1);
      end else if (cmd.pop_done || cmd.shift_done) begin
        count <= count - CW'(1);
      end
      if (cmd.pop_done) begin
        head <= wrap({1'b0, head}, (AW+1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key  <= item.value;
      kind <= item.kind;
      idx  <= IW'(1);
    end else if (cmd.scan_step || cmd.shift_start || cmd.shift_step) begin
      idx <= idx + IW'(1);
    end
    if (cmd.shift_start) begin
      pos <= idx - IW'(1);
    end

    if (cmd.quick) begin
      result.out_value <= '0;
      result.position  <= '0;
      case (item.kind)
        fwsr_pkg::KIND_PUSH: begin
          if (full) begin
            result.status <= fwsr_pkg::STATUS_FULL;
            result.length <= LW'(count);
          end else begin
            result.status <= fwsr_pkg::STATUS_OK;
            result.length <= LW'(count + CW'(1));
          end
        end
        fwsr_pkg::KIND_POP: begin
          result.status <= fwsr_pkg::STATUS_EMPTY;
          result.length <= LW'(count);
        end
        default: begin
          result.status <= fwsr_pkg::STATUS_NOTFOUND;
          result.length <= LW'(count);
        end
      endcase
    end else if (cmd.pop_done) begin
      result.status    <= fwsr_pkg::STATUS_OK;
      result.out_value <= rdata;
      result.position  <= '0;
      result.length    <= LW'(count - CW'(1));
    end else if (cmd.find_hit) begin
      result.status    <= fwsr_pkg::STATUS_OK;
      result.out_value <= '0;
      result.position  <= PW'(idx - IW'(1));
      result.length    <= LW'(count);
    end else if (cmd.miss) begin
      result.status    <= fwsr_pkg::STATUS_NOTFOUND;
      result.out_value <= '0;
      result.position  <= '0;
      result.length    <= LW'(count);
    end else if (cmd.shift_done) begin
      result.status    <= fwsr_pkg::STATUS_OK;
      result.out_value <= '0;
      result.position  <= PW'(pos);
      result.length    <= LW'(count - CW'(1));
    end
  end

endmodule

/* sv/fifo_with_search_and_remove.sv */
// ----------------------------------------------------------------------------
// fifo_with_search_and_remove
// Bounded queue of signed words with push, pop, find and remove-first-match.
// ----------------------------------------------------------------------------
//  channel  ports                      transfer
//  input    start, busy, item          start high while busy low
//  result   done, result               done high for one cycle
//
//  Push, and any operation on an empty queue: result in the cycle after accept.
//  Pop: result after one registered read of the head slot and the ST_POP state.
//  Find: walks the entries from the head until a match or the last valid entry;
//  remove then shifts the tail down over the match, one store write per cycle.
//  The single read port of the store keeps busy high until a pop, find or remove ends.
//  Reset clears state, count, head and done only; busy is low right after reset.
//  The result side has no back-pressure.
// ----------------------------------------------------------------------------
`include "fifo_with_search_and_remove_macros.svh"

module fifo_with_search_and_remove #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fwsr_pkg::item_t   item,
  output logic              done,
  output fwsr_pkg::result_t result
);

  fwsr_pkg::cmd_t  cmd;
  fwsr_pkg::stat_t st;
  logic            accept;
  logic            res_fail;
  logic            res_empty;

  assign accept    = start && !busy;
  assign res_fail  = done && (result.status != fwsr_pkg::STATUS_OK);
  assign res_empty = done && (result.status == fwsr_pkg::STATUS_EMPTY);

  fwsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_kind (item.kind),
    .st      (st),
    .busy    (busy),
    .cmd     (cmd)
  );

  fwsr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .done   (done),
    .result (result)
  );

  `FWSR_ASSERT_NEXT(a_accept_progress, accept, done || busy, "accepted item lost")
  `FWSR_ASSERT_NOW(a_fail_no_value, res_fail, result.out_value == '0, "failure carried a value")
  `FWSR_ASSERT_NOW(a_empty_len, res_empty, result.length == '0, "empty pop with nonzero length")

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks fifo_with_search_and_remove against a queue-based predictor. A
// directed opening covers empty and full queues, extreme values, and hits at
// the head, middle and tail. Random phases then fill and drain the queue. In
// these phases most find and remove keys come from the current contents.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fwsr_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = DEPTH + 8;
  localparam int PRINT_MAX   = 40;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_NEG = -32'sd1;

  class queue_scoreboard;
    logic signed [DATA_W-1:0] mirror[$];
    result_t                  expected_results[$];
    int                       errors = 0;

    task report_mismatch(input string msg);
      if (errors < PRINT_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    // first index of key in the mirror, -1 when absent
    function int find_key(input logic signed [DATA_W-1:0] key);
      foreach (mirror[i])
        if (mirror[i] === key) return i;
      return -1;
    endfunction

    function void note_item(input item_t it);
      result_t r;
      int      idx;
      r = '0;
      r.status = STATUS_OK;
      case (it.kind)
        KIND_PUSH: begin
          if (mirror.size() >= DEPTH) r.status = STATUS_FULL;
          else mirror.push_back(it.value);
        end
        KIND_POP: begin
          if (mirror.size() == 0) r.status = STATUS_EMPTY;
          else r.out_value = mirror.pop_front();
        end
        default: begin
          idx = find_key(it.value);
          if (idx < 0) begin
            r.status = STATUS_NOTFOUND;
          end else begin
            r.position = POS_W'(idx);
            if (it.kind == KIND_REMOVE) mirror.delete(idx);
          end
        end
      endcase
      r.length = LEN_W'(mirror.size());
      expected_results.push_back(r);
    endfunction

    task check_result(input result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no transfer outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.out_value !== want.out_value)
        report_mismatch($sformatf("out_value got %0d want %0d",
                                  got.out_value, want.out_value));
      if (got.position !== want.position)
        report_mismatch($sformatf("position got %0d want %0d",
                                  got.position, want.position));
      if (got.length !== want.length)
        report_mismatch($sformatf("length got %0d want %0d", got.length, want.length));
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  queue_scoreboard sb = new();
  int              stall_cycles = 0;
  bit              gaps_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fifo_with_search_and_remove #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // result is checked before a same-edge input transfer is noted
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_item(item);
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input kind_t k, input logic signed [DATA_W-1:0] v);
    while (gaps_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    item.kind  <= k;
    item.value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every transfer has its result
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 30) return DATA_W'(int'($urandom_range(8)) - 4);
    if (r < 40) begin
      case ($urandom_range(3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return VAL_NEG;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  task automatic run_phase(input int n, input int w_push, input int w_pop,
                           input int w_find);
    int                       r;
    kind_t                    k;
    logic signed [DATA_W-1:0] v;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < w_push) k = KIND_PUSH;
      else if (r < w_push + w_pop) k = KIND_POP;
      else if (r < w_push + w_pop + w_find) k = KIND_FIND;
      else k = KIND_REMOVE;
      v = pick_value();
      // mostly search for something that is there
      if (k inside {KIND_FIND, KIND_REMOVE} && sb.mirror.size() > 0 &&
          $urandom_range(99) < 70)
        v = sb.mirror[$urandom_range(sb.mirror.size() - 1)];
      send_item(k, v);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue on every operation
    send_item(KIND_POP, VAL_MAX);
    send_item(KIND_FIND, '0);
    send_item(KIND_REMOVE, VAL_NEG);
    send_item(KIND_PUSH, VAL_MAX);
    send_item(KIND_PUSH, VAL_MIN);
    send_item(KIND_PUSH, VAL_NEG);
    send_item(KIND_FIND, VAL_MIN);
    send_item(KIND_FIND, 32'sd12345);
    send_item(KIND_REMOVE, VAL_MAX);
    send_item(KIND_POP, '0);
    // removal empties the queue, which must still accept pushes
    send_item(KIND_REMOVE, VAL_NEG);
    send_item(KIND_PUSH, '0);
    for (int i = 0; i < DEPTH - 1; i++)
      send_item(KIND_PUSH, 32'sh1000_0000 + i);
    send_item(KIND_PUSH, VAL_MIN);
    send_item(KIND_FIND, 32'sh1000_0000 + DEPTH - 2);
    send_item(KIND_REMOVE, 32'sh1000_0000 + DEPTH - 2);
    wait_drained();

    run_phase(400, 55, 15, 15);
    wait_drained();
    run_phase(400, 15, 35, 20);
    wait_drained();
    gaps_on = 1'b0;
    run_phase(400, 30, 25, 20);
    gaps_on = 1'b1;
    run_phase(400, 35, 25, 20);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/fwsr_pkg.sv
sv/fwsr_ctrl.sv
sv/fwsr_dpath.sv
sv/fifo_with_search_and_remove.sv
sim/tb_top.sv
